>>> src/rsmp_pkg.sv
// Shared types and constants of the linear interpolating resampler.
package rsmp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StepW   = 24;
  localparam int unsigned PhaseW  = StepW + 1;
  localparam int unsigned FracW   = 16;

  localparam logic [StepW-1:0]  StepReset = 24'h010000;
  localparam logic [StepW-1:0]  StepMin   = 24'h000400;
  localparam logic [PhaseW-1:0] PhaseOne  = 25'h0010000;

  typedef struct packed {
    logic take_in;
    logic store_first;
    logic load_diff;
    logic emit;
    logic finish;
  } rsmp_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic phase_ge_one;
    logic out_free;
  } rsmp_status_t;

endpackage

>>> src/rsmp_dp.sv
// Datapath: sample, phase and step registers, interpolator and output register.
module rsmp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rsmp_pkg::rsmp_cmd_t               cmd_i,
  output rsmp_pkg::rsmp_status_t            status_o,
  input  logic                              cfg_we_i,
  input  logic [rsmp_pkg::StepW-1:0]        cfg_wdata_i,
  input  logic signed [rsmp_pkg::SampleW-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rsmp_pkg::SampleW-1:0] sample_out_o,
  output logic                              last_o
);
  import rsmp_pkg::*;

  logic [StepW-1:0]          step_q;
  logic signed [SampleW-1:0] x_q;
  logic signed [SampleW-1:0] prev_q, prev_d;
  logic                      have_prev_q, have_prev_d;
  logic [PhaseW-1:0]         phase_q, phase_d;
  logic [SampleW-1:0]        mag_q;
  logic                      neg_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_data_q;
  logic                      out_last_q;

  logic [StepW-1:0]          step_eff;
  logic [PhaseW-1:0]         step_sum;
  logic [PhaseW-1:0]         phase_dec;
  logic signed [SampleW:0]   diff;
  logic [SampleW:0]          diff_abs;
  logic [2*SampleW-1:0]      prod;
  logic [SampleW-1:0]        part;
  logic [SampleW:0]          interp;

  assign step_eff  = (step_q < StepMin) ? StepMin : step_q;
  assign step_sum  = phase_q + {1'b0, step_eff};
  assign phase_dec = phase_q - PhaseOne;
  assign diff      = {x_q[SampleW-1], x_q} - {prev_q[SampleW-1], prev_q};
  assign diff_abs  = diff[SampleW] ? (~diff + 1'b1) : diff;
  assign prod      = mag_q * phase_q[FracW-1:0];
  assign part      = prod[2*SampleW-1:FracW];
  assign interp    = neg_q ? ({prev_q[SampleW-1], prev_q} - {1'b0, part})
                           : ({prev_q[SampleW-1], prev_q} + {1'b0, part});

  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    phase_d     = phase_q;
    if (cmd_i.store_first) begin
      prev_d      = sample_in_i;
      have_prev_d = 1'b1;
    end
    if (cmd_i.emit) begin
      phase_d = step_sum;
    end
    if (cmd_i.finish) begin
      phase_d = {1'b0, phase_dec[StepW-1:0]};
      prev_d  = x_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepReset;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.load_diff) begin
      mag_q <= diff_abs[SampleW-1:0];
      neg_q <= diff[SampleW];
    end
    if (cmd_i.emit) begin
      out_data_q <= interp[SampleW-1:0];
      out_last_q <= (step_sum[PhaseW-1:FracW] != '0);
    end
  end

  assign status_o.have_prev    = have_prev_q;
  assign status_o.phase_ge_one = (phase_q[PhaseW-1:FracW] != '0);
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;
  assign last_o       = out_last_q;

endmodule

>>> src/rsmp_ctrl.sv
// Controller: sequences accept, difference load, output loop and phase wrap.
module rsmp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rsmp_pkg::rsmp_status_t status_i,
  output rsmp_pkg::rsmp_cmd_t    cmd_o
);
  import rsmp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_xfer;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.take_in     = in_xfer;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (status_i.have_prev) begin
            state_d = StPrep;
          end else begin
            cmd_o.store_first = 1'b1;
          end
        end
      end
      StPrep: begin
        cmd_o.load_diff = 1'b1;
        state_d         = StRun;
      end
      StRun: begin
        if (status_i.phase_ge_one) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == StRun) && !status_i.phase_ge_one && status_i.out_free)
    else $error("emit outside of a free output loop step");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == StIdle))
    else $error("finish did not return to idle");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && status_i.have_prev) |=> (state_q == StPrep))
    else $error("transfer with stored sample did not start preparation");

  a_first_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !status_i.have_prev) |=> status_i.have_prev && (state_q == StIdle))
    else $error("first sample not stored");
`endif

endmodule

>>> src/linear_interpolating_resampler_core.sv
// Top level of the linear interpolating sample rate converter.
// Each input transfer carries one signed 16-bit sample; the first after reset is only
// stored. Each later sample yields zero to 64 outputs, prev + (x - prev) * phase, while
// the Q9.16 read phase is below 1.0, the phase advancing by step_ratio (clamped to at
// least 1/64) per output; last_o marks the final output of that sample. An item passes
// through acceptance, one difference load, one output per cycle through the
// single 16x16 interpolation multiplier while the output side does not stall, then one
// phase wrap. Input is taken only while the controller is idle; a finished output may
// still wait in the output register meanwhile.
// Write step_ratio via cfg_we_i only when idle.
module linear_interpolating_resampler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rsmp_pkg::StepW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rsmp_pkg::SampleW-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rsmp_pkg::SampleW-1:0] sample_out_o,
  output logic                                last_o
);
  import rsmp_pkg::*;

  rsmp_cmd_t    cmd;
  rsmp_status_t status;

  rsmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsmp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .last_o       (last_o)
  );

endmodule
